// ===== rtl/amr_coarse_grid_allocator_macros.svh =====
// Assertion macros shared by the checker files.
// AMRCGA_ASSERT_NOW checks the consequent in the same cycle,
// AMRCGA_ASSERT_NEXT in the cycle after the antecedent. Both sample on aclk
// and stay quiet while aresetn is low.
`ifndef AMR_COARSE_GRID_ALLOCATOR_MACROS_SVH
`define AMR_COARSE_GRID_ALLOCATOR_MACROS_SVH

`define AMRCGA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define AMRCGA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/amrcga_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amrcga_pkg
// Shared widths, codes, defaults and helpers of the coarse grid allocator.
// ----------------------------------------------------------------------------
package amrcga_pkg;

    localparam int MAX_GRIDS_DEF  = 1024;
    localparam int MAX_COARSE_DEF = 4096;
    localparam int CPU_COUNT_DEF  = 16;

    localparam int COORD_W  = 4;
    localparam int SIZE_W   = 5;
    localparam int CPU_W    = 4;
    localparam int STATUS_W = 2;
    localparam int GRID_W   = 11;
    localparam int CTR_W    = 5;
    localparam int NB_W     = 13;
    localparam int CIDX_W   = 12;
    localparam int YNX_W    = 8;
    localparam int NXNY_W   = 9;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 104;
    localparam int REG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd8;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 5'd16;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_MADE = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_SKIP = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic               in_range;
        logic [CIDX_W-1:0]  cell0;
        logic [COORD_W-1:0] xm;
        logic [COORD_W-1:0] xp;
        logic [YNX_W-1:0]   ynx;
        logic [YNX_W-1:0]   ymnx;
        logic [YNX_W-1:0]   ypnx;
        logic [CIDX_W-1:0]  znn;
        logic [CIDX_W-1:0]  zmnn;
        logic [CIDX_W-1:0]  zpnn;
    } geom_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = 5'd1;
        end else if (s > SIZE_MAX) begin
            r = SIZE_MAX;
        end
        return r;
    endfunction

endpackage

// ===== rtl/amrcga_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amrcga_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module amrcga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/amrcga_geom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amrcga_geom
// Cell index of the visited cell and the row/plane offsets of its periodic
// neighbours; the offsets are registered for the next cycle.
// ----------------------------------------------------------------------------
module amrcga_geom (
    input  logic                          aclk,
    input  logic                          load,
    input  logic [amrcga_pkg::COORD_W-1:0] x,
    input  logic [amrcga_pkg::COORD_W-1:0] y,
    input  logic [amrcga_pkg::COORD_W-1:0] z,
    input  logic [amrcga_pkg::SIZE_W-1:0]  nx,
    input  logic [amrcga_pkg::SIZE_W-1:0]  ny,
    input  logic [amrcga_pkg::SIZE_W-1:0]  nz,
    input  logic [amrcga_pkg::NXNY_W-1:0]  nxny,
    output logic [amrcga_pkg::CIDX_W-1:0]  cell0,
    output amrcga_pkg::geom_t             geom
);
    import amrcga_pkg::*;

    logic [COORD_W-1:0] xm, xp, ym, yp, zm, zp;
    logic [YNX_W-1:0]   ynx, ymnx, ypnx;
    logic [CIDX_W-1:0]  znn, zmnn, zpnn;
    logic               in_range;
    geom_t              geom_reg;

    always_comb begin
        xm = (x != '0) ? x - 4'd1 : COORD_W'(nx - 5'd1);
        xp = ((SIZE_W'(x) + 5'd1) < nx) ? x + 4'd1 : '0;
        ym = (y != '0) ? y - 4'd1 : COORD_W'(ny - 5'd1);
        yp = ((SIZE_W'(y) + 5'd1) < ny) ? y + 4'd1 : '0;
        zm = (z != '0) ? z - 4'd1 : COORD_W'(nz - 5'd1);
        zp = ((SIZE_W'(z) + 5'd1) < nz) ? z + 4'd1 : '0;

        ynx  = YNX_W'(y)  * YNX_W'(nx);
        ymnx = YNX_W'(ym) * YNX_W'(nx);
        ypnx = YNX_W'(yp) * YNX_W'(nx);
        znn  = CIDX_W'(z)  * CIDX_W'(nxny);
        zmnn = CIDX_W'(zm) * CIDX_W'(nxny);
        zpnn = CIDX_W'(zp) * CIDX_W'(nxny);

        in_range = (SIZE_W'(x) < nx) && (SIZE_W'(y) < ny) && (SIZE_W'(z) < nz);
        cell0    = CIDX_W'(x) + CIDX_W'(ynx) + znn;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            geom_reg.in_range <= in_range;
            geom_reg.cell0    <= cell0;
            geom_reg.xm       <= xm;
            geom_reg.xp       <= xp;
            geom_reg.ynx      <= ynx;
            geom_reg.ymnx     <= ymnx;
            geom_reg.ypnx     <= ypnx;
            geom_reg.znn      <= znn;
            geom_reg.zmnn     <= zmnn;
            geom_reg.zpnn     <= zpnn;
        end
    end

    assign geom = geom_reg;

endmodule

// ===== rtl/amr_coarse_grid_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_coarse_grid_allocator
// Coarse cell visitor: allocates a child grid from the free list for a
// flagged, unrefined cell and appends it to the owner cpu's level-1 list.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per visited coarse cell (coordinates, two flags,
//   owner cpu). m_ channel: one beat per input beat, status on m_tuser,
//   grid number, centre and six wrapped neighbour indices on m_tdata. The
//   user sets sizes over the cfg write port while idle; the block won't check.
// Sequencing:
//   One item at a time. An accepted item passes a read state for the
//   registered read of the child-link memory, a decide state that loads
//   the result register, a link state for the second write into the link
//   memory only when the grid is linked behind an existing list tail, and
//   an output state. s_tready returns at the edge that loads the result,
//   so the next beat enters while the result still waits.
// Reset:
//   aresetn clears control state, restores sizes to 8 and the free list to
//   grids 1..MAX_GRIDS in order, then sweeps all MAX_COARSE entries of the
//   child-link memory to zero; s_tready stays low during the sweep.
// Stall:
//   With m_tready low the result holds in the output register and the
//   next result waits in its own stage; no beat is lost.
// ----------------------------------------------------------------------------
module amr_coarse_grid_allocator #(
    parameter int MAX_GRIDS  = amrcga_pkg::MAX_GRIDS_DEF,
    parameter int MAX_COARSE = amrcga_pkg::MAX_COARSE_DEF,
    parameter int CPU_COUNT  = amrcga_pkg::CPU_COUNT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // cfg write port
    input  logic                             cfg_we,
    input  logic [amrcga_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [amrcga_pkg::SIZE_W-1:0]    cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cell_x[3:0] cell_y[7:4] cell_z[11:8] mark_first[12] mark_second[13]
    // owner_cpu[17:14], zero fill above
    input  logic [amrcga_pkg::IN_W-1:0]      s_tdata,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // grid_number[10:0] centre_x[15:11] centre_y[20:16] centre_z[25:21]
    // left_cell[38:26] right_cell[51:39] down_cell[64:52] up_cell[77:65]
    // back_cell[90:78] front_cell[103:91]
    output logic [amrcga_pkg::OUT_W-1:0]     m_tdata,
    // status[1:0]
    output logic [amrcga_pkg::STATUS_W-1:0]  m_tuser
);
    import amrcga_pkg::*;

    localparam int GW  = $clog2(MAX_GRIDS + 1);
    localparam int LW  = $clog2(MAX_GRIDS);
    localparam int CW  = (MAX_COARSE > 1) ? $clog2(MAX_COARSE) : 1;
    localparam int CPW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_LINK   = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [SIZE_W-1:0]   size_x_reg, size_y_reg, size_z_reg;
    logic [SIZE_W-1:0]   nx_reg, ny_reg, nz_reg;
    logic [NXNY_W-1:0]   nxny_reg;
    logic [COORD_W-1:0]  x_reg, y_reg, z_reg;
    logic                mark_ok_reg;
    logic [CPU_W-1:0]    cpu_reg;
    logic [GW-1:0]       head_reg, head_next;
    logic [GW-1:0]       alloc_reg, alloc_next;
    logic [GW-1:0]       tail_reg [CPU_COUNT];
    logic [CPU_COUNT-1:0] busy_reg;
    logic [GW-1:0]       link_tail_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [OUT_W-1:0]    res_data_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;

    logic [SIZE_W-1:0]   nx_c, ny_c, nz_c;
    logic [CIDX_W-1:0]   cell0;
    geom_t               geom;
    logic [CPW-1:0]      cpu_idx;

    logic                child_we;
    logic [CW-1:0]       child_waddr;
    logic [GW-1:0]       child_wdata;
    logic [GW-1:0]       child_rdata;
    logic                link_we;
    logic [LW-1:0]       link_waddr;
    logic [GW-1:0]       link_wdata;
    logic [GW-1:0]       link_rdata;
    logic [GW-1:0]       head_m1;

    logic                accept;
    logic                skip, full, made;
    logic [GW-1:0]       fwd_val;
    logic [STATUS_W-1:0] status_c;
    logic [NB_W-1:0]     base, left_c, right_c, down_c, up_c, back_c, front_c;
    logic [OUT_W-1:0]    data_c;
    logic                out_free;

    assign nx_c    = clamp_size(size_x_reg);
    assign ny_c    = clamp_size(size_y_reg);
    assign nz_c    = clamp_size(size_z_reg);
    assign cpu_idx = CPW'(cpu_reg);
    assign head_m1 = head_reg - GW'(1);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    amrcga_geom u_geom (
        .aclk  (aclk),
        .load  (state_reg == S_READ),
        .x     (x_reg),
        .y     (y_reg),
        .z     (z_reg),
        .nx    (nx_reg),
        .ny    (ny_reg),
        .nz    (nz_reg),
        .nxny  (nxny_reg),
        .cell0 (cell0),
        .geom  (geom)
    );

    amrcga_ram #(.WIDTH(GW), .DEPTH(MAX_COARSE), .AW(CW)) u_child_ram (
        .aclk    (aclk),
        .wr_en   (child_we),
        .wr_addr (child_waddr),
        .wr_data (child_wdata),
        .rd_addr (CW'(cell0)),
        .rd_data (child_rdata)
    );

    amrcga_ram #(.WIDTH(GW), .DEPTH(MAX_GRIDS), .AW(LW)) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_addr (LW'(head_m1)),
        .rd_data (link_rdata)
    );

    // decision on the item in flight
    always_comb begin
        skip = !geom.in_range || (int'(cpu_reg) >= CPU_COUNT)
            || (int'(geom.cell0) >= MAX_COARSE) || !mark_ok_reg
            || (child_rdata != '0);
        full = (alloc_reg == GW'(MAX_GRIDS)) || (head_reg == '0)
            || (int'(head_reg) > MAX_GRIDS);
        made = !skip && !full;
        if (skip) begin
            status_c = STAT_SKIP;
        end else if (full) begin
            status_c = STAT_FULL;
        end else begin
            status_c = STAT_MADE;
        end

        // entries at or above the allocation count still hold their reset link
        if (int'(head_m1) < int'(alloc_reg)) begin
            fwd_val = link_rdata;
        end else if (int'(head_reg) < MAX_GRIDS) begin
            fwd_val = head_reg + GW'(1);
        end else begin
            fwd_val = '0;
        end

        base    = NB_W'(1) + NB_W'(x_reg);
        left_c  = NB_W'(1) + NB_W'(geom.xm) + NB_W'(geom.ynx) + NB_W'(geom.znn);
        right_c = NB_W'(1) + NB_W'(geom.xp) + NB_W'(geom.ynx) + NB_W'(geom.znn);
        down_c  = base + NB_W'(geom.ymnx) + NB_W'(geom.znn);
        up_c    = base + NB_W'(geom.ypnx) + NB_W'(geom.znn);
        back_c  = base + NB_W'(geom.ynx) + NB_W'(geom.zmnn);
        front_c = base + NB_W'(geom.ynx) + NB_W'(geom.zpnn);

        data_c = {front_c, back_c, up_c, down_c, right_c, left_c,
                  z_reg, 1'b1, y_reg, 1'b1, x_reg, 1'b1, GRID_W'(head_reg)};
        if (!made) begin
            data_c = '0;
        end
    end

    // memory write ports
    always_comb begin
        child_we    = 1'b0;
        child_waddr = CW'(geom.cell0);
        child_wdata = head_reg;
        link_we     = 1'b0;
        link_waddr  = LW'(head_m1);
        link_wdata  = '0;
        case (state_reg)
            S_CLEAR: begin
                child_we    = 1'b1;
                child_waddr = clr_cnt_reg;
                child_wdata = '0;
            end
            S_DECIDE: begin
                child_we = made;
                link_we  = made;
            end
            S_LINK: begin
                // the tail table already holds the new grid
                link_we    = 1'b1;
                link_waddr = LW'(link_tail_reg - GW'(1));
                link_wdata = tail_reg[cpu_idx];
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        head_next    = head_reg;
        alloc_next   = alloc_reg;
        case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(MAX_COARSE - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                state_next = S_OUT;
                if (made) begin
                    // pop the free-list head before its link is cleared
                    alloc_next = alloc_reg + GW'(1);
                    head_next  = fwd_val;
                    if (busy_reg[cpu_idx]) begin
                        state_next = S_LINK;
                    end
                end
            end
            S_LINK: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            size_x_reg   <= SIZE_RESET;
            size_y_reg   <= SIZE_RESET;
            size_z_reg   <= SIZE_RESET;
            head_reg     <= GW'(1);
            alloc_reg    <= '0;
            busy_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            head_reg    <= head_next;
            alloc_reg   <= alloc_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_SIZE_X: size_x_reg <= cfg_wdata;
                    REG_SIZE_Y: size_y_reg <= cfg_wdata;
                    REG_SIZE_Z: size_z_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (state_reg == S_DECIDE && made) begin
                busy_reg[cpu_idx] <= 1'b1;
            end
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg       <= s_tdata[3:0];
            y_reg       <= s_tdata[7:4];
            z_reg       <= s_tdata[11:8];
            mark_ok_reg <= s_tdata[12] && s_tdata[13];
            cpu_reg     <= s_tdata[17:14];
            nx_reg      <= nx_c;
            ny_reg      <= ny_c;
            nz_reg      <= nz_c;
            nxny_reg    <= NXNY_W'(nx_c) * NXNY_W'(ny_c);
        end
        if (state_reg == S_DECIDE) begin
            res_status_reg <= status_c;
            res_data_reg   <= data_c;
            if (made) begin
                link_tail_reg     <= tail_reg[cpu_idx];
                tail_reg[cpu_idx] <= head_reg;
            end
        end
        if (state_reg == S_OUT && out_free) begin
            m_tdata_reg <= res_data_reg;
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/amrcga_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amrcga_checker
// Port-level checks of the coarse grid allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "amr_coarse_grid_allocator_macros.svh"

module amrcga_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [amrcga_pkg::OUT_W-1:0]    m_tdata,
    input logic [amrcga_pkg::STATUS_W-1:0] m_tuser
);
    import amrcga_pkg::*;

    // a stalled result beat holds
    `AMRCGA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // one item in flight: no second beat right after an accepted one
    `AMRCGA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input taken while an item is in flight")

    // results that made no grid carry an all-zero payload
    `AMRCGA_ASSERT_NOW(a_zero_payload, m_tvalid && m_tuser != STAT_MADE, m_tdata == '0, "nonzero payload without a grid")

    // a made grid has a nonzero number and odd centres
    `AMRCGA_ASSERT_NOW(a_made_fields, m_tvalid && m_tuser == STAT_MADE, m_tdata[10:0] != '0 && m_tdata[11] && m_tdata[16] && m_tdata[21], "bad grid number or centre")

endmodule

bind amr_coarse_grid_allocator amrcga_checker u_amrcga_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/tb_amr_coarse_grid_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_amr_coarse_grid_allocator
// Self-checking bench for the coarse grid allocator. A directed table covers
// the flag combinations, range checks, periodic wrap at both ends and size
// clamping; random phases at several mesh sizes follow, then a short raster
// sweep over the full mesh. Every result beat is compared field by field
// with its table row when typed, else with an in-bench allocator that keeps
// its own free list, level lists and child links. Both stream sides idle at
// random; the result side holds off for long stretches so the block backs up.
// ----------------------------------------------------------------------------
module tb_amr_coarse_grid_allocator;
    import amrcga_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 75;
    localparam int NUM_DIRECTED   = 26;
    localparam int SWEEP_ITEMS    = 60;
    localparam logic [SIZE_W-1:0] PHASE_SIZES [5][3] = '{
        '{16, 16, 16}, '{1, 1, 1}, '{0, 31, 5}, '{16, 1, 16}, '{3, 7, 2}};

    typedef struct packed {
        logic [5:0]         pad;
        logic [CPU_W-1:0]   owner_cpu;
        logic               mark_second;
        logic               mark_first;
        logic [COORD_W-1:0] cell_z;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_x;
    } cell_visit_t;

    typedef struct packed {
        logic [NB_W-1:0]   front_cell;
        logic [NB_W-1:0]   back_cell;
        logic [NB_W-1:0]   up_cell;
        logic [NB_W-1:0]   down_cell;
        logic [NB_W-1:0]   right_cell;
        logic [NB_W-1:0]   left_cell;
        logic [CTR_W-1:0]  centre_z;
        logic [CTR_W-1:0]  centre_y;
        logic [CTR_W-1:0]  centre_x;
        logic [GRID_W-1:0] grid_number;
    } grid_report_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        grid_report_t        rep;
    } alloc_result_t;

    typedef enum logic {ROW_VISIT, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e            kind;
        logic [REG_IDX_W-1:0] reg_index;
        logic [SIZE_W-1:0]    reg_value;
        logic [COORD_W-1:0]   x, y, z;
        logic                 first, second;
        logic [CPU_W-1:0]     cpu;
        logic                 typed;
        logic [STATUS_W-1:0]  status;
        logic [GRID_W-1:0]    grid;
        logic [CTR_W-1:0]     cx, cy, cz;
        logic [NB_W-1:0]      l, r, d, u, b, f;
    } stim_row_t;

    // kind, reg, value, x, y, z, flags, cpu, typed, status, grid, centre, neighbours
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{ROW_VISIT, REG_SIZE_X, 0, 0, 0, 0, 1, 1, 0, 1, STAT_MADE, 1,
          1, 1, 1, 8, 2, 57, 9, 449, 65},
        '{ROW_VISIT, REG_SIZE_X, 0, 0, 0, 0, 1, 1, 0, 1, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 1, 0, 0, 0, 1, 1, 1, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 1, 0, 0, 1, 0, 1, 1, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 1, 0, 0, 0, 0, 1, 1, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 7, 7, 7, 1, 1, 15, 1, STAT_MADE, 2,
          15, 15, 15, 511, 505, 504, 456, 448, 64},
        '{ROW_VISIT, REG_SIZE_X, 0, 8, 0, 0, 1, 1, 2, 1, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 0, 8, 0, 1, 1, 2, 1, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 0, 0, 8, 1, 1, 2, 1, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 15, 15, 15, 1, 1, 15, 1, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 3, 4, 5, 1, 1, 15, 0, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 1, 0, 0, 1, 1, 0, 0, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 2, 6, 1, 1, 1, 7, 0, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_SIZE_X, 16, 0, 0, 0, 0, 0, 0, 0, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_SIZE_Y, 16, 0, 0, 0, 0, 0, 0, 0, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_SIZE_Z, 16, 0, 0, 0, 0, 0, 0, 0, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 15, 15, 15, 1, 1, 3, 0, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 0, 0, 0, 1, 1, 3, 1, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_SIZE_X, 0, 0, 0, 0, 0, 0, 0, 0, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_SIZE_Y, 31, 0, 0, 0, 0, 0, 0, 0, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_SIZE_Z, 1, 0, 0, 0, 0, 0, 0, 0, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 0, 15, 0, 1, 1, 9, 0, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 1, 0, 0, 1, 1, 9, 1, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_SIZE_Z, 17, 0, 0, 0, 0, 0, 0, 0, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 0, 0, 15, 1, 1, 4, 0, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_VISIT, REG_SIZE_X, 0, 0, 0, 0, 1, 1, 12, 1, STAT_SKIP, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0}};

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // allocator state mirrored by the bench
    logic [SIZE_W-1:0] size_reg [3];
    logic [GRID_W-1:0] cell_child [MAX_COARSE_DEF];
    logic [NB_W-1:0]   grid_parent [MAX_GRIDS_DEF];
    logic [GRID_W-1:0] next_link [MAX_GRIDS_DEF];
    logic [GRID_W-1:0] prev_link [MAX_GRIDS_DEF];
    logic [GRID_W-1:0] free_top;
    logic [GRID_W-1:0] free_left;
    logic [GRID_W-1:0] list_head [CPU_COUNT_DEF];
    logic [GRID_W-1:0] list_tail [CPU_COUNT_DEF];
    logic [GRID_W-1:0] list_len [CPU_COUNT_DEF];

    alloc_result_t pending_reports [$];
    int errors;
    int results_seen;
    int idle_cycles;
    int calm_items;
    logic calm_mode;

    amr_coarse_grid_allocator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int eff_size(input logic [SIZE_W-1:0] s);
        if (s == '0) begin
            return 1;
        end
        if (s > 5'd16) begin
            return 16;
        end
        return int'(s);
    endfunction

    function automatic logic grid_ok(input int g);
        return g >= 1 && g <= MAX_GRIDS_DEF;
    endfunction

    // Pop a grid for the visited cell and link it behind the owner's list.
    function automatic alloc_result_t allocate_grid(input cell_visit_t v);
        alloc_result_t r;
        int nx, ny, nz, x, y, z, cell_idx, g, xm, xp, ym, yp, zm, zp, ynx, znn;
        logic [CPU_W-1:0] cpu;
        r.status = STAT_SKIP;
        r.rep    = '0;
        nx  = eff_size(size_reg[REG_SIZE_X]);
        ny  = eff_size(size_reg[REG_SIZE_Y]);
        nz  = eff_size(size_reg[REG_SIZE_Z]);
        x   = int'(v.cell_x);
        y   = int'(v.cell_y);
        z   = int'(v.cell_z);
        cpu = v.owner_cpu;
        if (x >= nx || y >= ny || z >= nz || int'(cpu) >= CPU_COUNT_DEF) begin
            return r;
        end
        cell_idx = 1 + x + y * nx + z * nx * ny;
        if (cell_idx > MAX_COARSE_DEF || !v.mark_first || !v.mark_second
            || cell_child[cell_idx-1] != '0) begin
            return r;
        end
        if (free_left == '0 || !grid_ok(int'(free_top))) begin
            r.status = STAT_FULL;
            return r;
        end
        g        = int'(free_top);
        free_top = next_link[g-1];
        if (grid_ok(int'(free_top))) begin
            prev_link[int'(free_top)-1] = '0;
        end
        free_left--;
        cell_child[cell_idx-1] = GRID_W'(g);
        grid_parent[g-1]       = NB_W'(cell_idx);
        next_link[g-1]         = '0;
        if (list_len[cpu] != '0 && grid_ok(int'(list_tail[cpu]))) begin
            prev_link[g-1]                    = list_tail[cpu];
            next_link[int'(list_tail[cpu])-1] = GRID_W'(g);
            list_tail[cpu]                    = GRID_W'(g);
            list_len[cpu]++;
        end else begin
            // empty or broken list: restart it with this grid alone
            prev_link[g-1] = '0;
            list_head[cpu] = GRID_W'(g);
            list_tail[cpu] = GRID_W'(g);
            list_len[cpu]  = GRID_W'(1);
        end
        xm  = (x > 0) ? x - 1 : nx - 1;
        xp  = (x + 1 < nx) ? x + 1 : 0;
        ym  = (y > 0) ? y - 1 : ny - 1;
        yp  = (y + 1 < ny) ? y + 1 : 0;
        zm  = (z > 0) ? z - 1 : nz - 1;
        zp  = (z + 1 < nz) ? z + 1 : 0;
        ynx = y * nx;
        znn = z * nx * ny;
        r.status             = STAT_MADE;
        r.rep.grid_number    = GRID_W'(g);
        r.rep.centre_x       = CTR_W'(2 * x + 1);
        r.rep.centre_y       = CTR_W'(2 * y + 1);
        r.rep.centre_z       = CTR_W'(2 * z + 1);
        r.rep.left_cell      = NB_W'(1 + xm + ynx + znn);
        r.rep.right_cell     = NB_W'(1 + xp + ynx + znn);
        r.rep.down_cell      = NB_W'(1 + x + ym * nx + znn);
        r.rep.up_cell        = NB_W'(1 + x + yp * nx + znn);
        r.rep.back_cell      = NB_W'(1 + x + ynx + zm * nx * ny);
        r.rep.front_cell     = NB_W'(1 + x + ynx + zp * nx * ny);
        return r;
    endfunction

    // Mostly well-formed visits inside the mesh; the rest is raw noise.
    function automatic cell_visit_t random_visit();
        cell_visit_t v;
        v           = '0;
        v.owner_cpu = CPU_W'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 80) begin
            v.cell_x      = COORD_W'($urandom_range(0, eff_size(size_reg[REG_SIZE_X]) - 1));
            v.cell_y      = COORD_W'($urandom_range(0, eff_size(size_reg[REG_SIZE_Y]) - 1));
            v.cell_z      = COORD_W'($urandom_range(0, eff_size(size_reg[REG_SIZE_Z]) - 1));
            v.mark_first  = 1'b1;
            v.mark_second = 1'b1;
        end else begin
            v.cell_x      = COORD_W'($urandom_range(0, 15));
            v.cell_y      = COORD_W'($urandom_range(0, 15));
            v.cell_z      = COORD_W'($urandom_range(0, 15));
            v.mark_first  = 1'($urandom_range(0, 1));
            v.mark_second = 1'($urandom_range(0, 1));
        end
        return v;
    endfunction

    function automatic int sender_gap();
        int r;
        if (calm_items == 0) begin
            calm_items = int'($urandom_range(20, 80));
            calm_mode  = ($urandom_range(0, 2) == 0);
        end
        calm_items--;
        if (calm_mode) begin
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return int'($urandom_range(1, 3));
        end else if (r < 97) begin
            return int'($urandom_range(4, 10));
        end
        return int'($urandom_range(20, 60));
    endfunction

    function automatic void check_field(input string name, input int expected,
                                        input int actual);
        if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
                     expected, actual);
            errors++;
        end
    endfunction

    // Offer one visit; returns at the edge where the beat is taken.
    task automatic drive_cell(input cell_visit_t v, input logic typed,
                              input alloc_result_t typed_res);
        int gap;
        alloc_result_t predicted;
        gap = sender_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        predicted = allocate_grid(v);
        pending_reports.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic write_size(input logic [REG_IDX_W-1:0] idx,
                              input logic [SIZE_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        size_reg[idx] = value;
    endtask

    // Result side: random ready pattern plus two long hold-offs.
    initial begin : result_sink
        int on_len, off_len, holds, r;
        holds    = 0;
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (holds < 2 && results_seen >= 200 + 300 * holds) begin
                holds++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            on_len = int'($urandom_range(1, 24));
            m_tready <= 1'b1;
            repeat (on_len) @(negedge aclk);
            r = int'($urandom_range(0, 99));
            if (r < 45) begin
                off_len = 0;
            end else if (r < 85) begin
                off_len = int'($urandom_range(1, 3));
            end else if (r < 97) begin
                off_len = int'($urandom_range(4, 10));
            end else begin
                off_len = int'($urandom_range(20, 60));
            end
            if (off_len > 0) begin
                m_tready <= 1'b0;
                repeat (off_len) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        alloc_result_t want;
        grid_report_t  got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            if (pending_reports.size() == 0) begin
                $display("%0t: result beat with none expected, got status %0d tdata %h",
                         $time, m_tuser, m_tdata);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                check_field("status",      int'(want.status),   int'(m_tuser));
                check_field("grid_number", int'(want.rep.grid_number),
                            int'(got.grid_number));
                check_field("centre_x",    int'(want.rep.centre_x),
                            int'(got.centre_x));
                check_field("centre_y",    int'(want.rep.centre_y),
                            int'(got.centre_y));
                check_field("centre_z",    int'(want.rep.centre_z),
                            int'(got.centre_z));
                check_field("left_cell",   int'(want.rep.left_cell),
                            int'(got.left_cell));
                check_field("right_cell",  int'(want.rep.right_cell),
                            int'(got.right_cell));
                check_field("down_cell",   int'(want.rep.down_cell),
                            int'(got.down_cell));
                check_field("up_cell",     int'(want.rep.up_cell),
                            int'(got.up_cell));
                check_field("back_cell",   int'(want.rep.back_cell),
                            int'(got.back_cell));
                check_field("front_cell",  int'(want.rep.front_cell),
                            int'(got.front_cell));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, pending_reports.size());
                $display("tb_amr_coarse_grid_allocator failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        cell_visit_t   v;
        alloc_result_t tr;
        stim_row_t     row;
        logic [SIZE_W-1:0] sx, sy, sz;
        logic [12:0]   cell_no;

        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_SIZE_X;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        errors       = 0;
        results_seen = 0;
        idle_cycles  = 0;
        calm_items   = 0;
        calm_mode    = 1'b0;

        // reset image: sizes 8, grids 1..N free in order, no lists, no children
        size_reg[REG_SIZE_X] = SIZE_RESET;
        size_reg[REG_SIZE_Y] = SIZE_RESET;
        size_reg[REG_SIZE_Z] = SIZE_RESET;
        for (int i = 0; i < MAX_COARSE_DEF; i++) begin
            cell_child[i] = '0;
        end
        for (int g = 1; g <= MAX_GRIDS_DEF; g++) begin
            grid_parent[g-1] = '0;
            next_link[g-1]   = GRID_W'((g < MAX_GRIDS_DEF) ? g + 1 : 0);
            prev_link[g-1]   = GRID_W'(g - 1);
        end
        free_top  = GRID_W'(1);
        free_left = GRID_W'(MAX_GRIDS_DEF);
        for (int c = 0; c < CPU_COUNT_DEF; c++) begin
            list_head[c] = '0;
            list_tail[c] = '0;
            list_len[c]  = '0;
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE) begin
                drain();
                write_size(row.reg_index, row.reg_value);
            end else begin
                v                    = '0;
                v.cell_x             = row.x;
                v.cell_y             = row.y;
                v.cell_z             = row.z;
                v.mark_first         = row.first;
                v.mark_second        = row.second;
                v.owner_cpu          = row.cpu;
                tr.status            = row.status;
                tr.rep.grid_number   = row.grid;
                tr.rep.centre_x      = row.cx;
                tr.rep.centre_y      = row.cy;
                tr.rep.centre_z      = row.cz;
                tr.rep.left_cell     = row.l;
                tr.rep.right_cell    = row.r;
                tr.rep.down_cell     = row.d;
                tr.rep.up_cell       = row.u;
                tr.rep.back_cell     = row.b;
                tr.rep.front_cell    = row.f;
                drive_cell(v, row.typed, tr);
            end
        end

        for (int p = 0; p < 7; p++) begin
            if (p < 5) begin
                sx = PHASE_SIZES[p][0];
                sy = PHASE_SIZES[p][1];
                sz = PHASE_SIZES[p][2];
            end else begin
                sx = SIZE_W'($urandom_range(0, 31));
                sy = SIZE_W'($urandom_range(0, 31));
                sz = SIZE_W'($urandom_range(0, 31));
            end
            drain();
            write_size(REG_SIZE_X, sx);
            write_size(REG_SIZE_Y, sy);
            write_size(REG_SIZE_Z, sz);
            repeat (PHASE_ITEMS) drive_cell(random_visit(), 1'b0, '0);
        end

        // raster walk from the first cell of the full mesh
        drain();
        write_size(REG_SIZE_X, SIZE_MAX);
        write_size(REG_SIZE_Y, SIZE_MAX);
        write_size(REG_SIZE_Z, SIZE_MAX);
        cell_no = '0;
        while (int'(cell_no) < SWEEP_ITEMS) begin
            v             = '0;
            v.cell_x      = cell_no[3:0];
            v.cell_y      = cell_no[7:4];
            v.cell_z      = cell_no[11:8];
            v.mark_first  = 1'b1;
            v.mark_second = 1'b1;
            v.owner_cpu   = cell_no[3:0] ^ cell_no[7:4];
            drive_cell(v, 1'b0, '0);
            cell_no++;
        end

        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_amr_coarse_grid_allocator passed");
        end else begin
            $display("tb_amr_coarse_grid_allocator failed");
        end
        $finish;
    end

endmodule

// ===== amr_coarse_grid_allocator.f =====
+incdir+rtl
rtl/amrcga_pkg.sv
rtl/amrcga_ram.sv
rtl/amrcga_geom.sv
rtl/amr_coarse_grid_allocator.sv
rtl/amrcga_checker.sv
test/tb_amr_coarse_grid_allocator.sv
